FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// expects a clock named clock and a synchronous active-high reset named reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequence in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/jtco_pkg.sv
// types, constants and direction tables for the joystick to chamber openings block
// no dependencies
package jtco_pkg;

   localparam int BUTTONS    = 6;
   localparam int ROOT_STEPS = 24;
   localparam int QUOT_BITS  = 17;

   localparam logic [17:0] FREQ_RESET = 18'd800;
   localparam logic [17:0] FREQ_MAX   = 18'd200000;
   localparam logic [6:0]  COUNT_RESET = 7'd100;
   localparam logic signed [15:0] TRIGGER_LEVEL = 16'sd100;

   // register indexes
   localparam logic [2:0] REG_DEAD_ZONE   = 3'd0;
   localparam logic [2:0] REG_SAT_LIMIT   = 3'd1;
   localparam logic [2:0] REG_PERIOD      = 3'd2;
   localparam logic [2:0] REG_EXTEND      = 3'd3;
   localparam logic [2:0] REG_CONTRACT    = 3'd4;

   localparam logic [14:0] DEAD_ZONE_RESET = 15'd8000;
   localparam logic [14:0] SAT_LIMIT_RESET = 15'd30000;
   localparam logic [6:0]  PERIOD_RESET    = 7'd20;
   localparam logic [15:0] EXTEND_RESET    = 16'd8192;
   localparam logic [15:0] CONTRACT_RESET  = 16'hCCCD;

   typedef struct packed {
      logic [14:0] dead_zone;
      logic [14:0] saturation_limit;
      logic [6:0]  check_period;
      logic [15:0] extend_opening;
      logic [15:0] contract_opening;
   } jtco_cfg_type;

   typedef struct packed {
      logic [15:0] left_stick_y;
      logic [15:0] trigger_up;
      logic [15:0] trigger_down;
      logic [15:0] right_stick_x;
      logic [15:0] right_stick_y;
      logic [5:0]  button_mask;
   } jtco_item_type;

   typedef struct packed {
      logic       load;
      logic       square;
      logic       root_init;
      logic       root_step;
      logic       den;
      logic       dot;
      logic       sum;
      logic       prod;
      logic       numer;
      logic       div_step;
      logic       emit_bend;
      logic       emit_base;
      logic [2:0] chamber;
      logic       last;
   } jtco_cmd_type;

   typedef struct packed {
      logic [5:0] buttons;
      logic       buttons_zero;
      logic       out_free;
   } jtco_sts_type;

   // chamber directions repeat every six chambers
   function automatic logic signed [15:0] dir_cos(input logic [2:0] idx);
      logic signed [15:0] c;
      case (idx)
         3'd0, 3'd6: c = 16'sd16384;
         3'd1, 3'd7: c = 16'sd8192;
         3'd2:       c = -16'sd8192;
         3'd3:       c = -16'sd16384;
         3'd4:       c = -16'sd8192;
         3'd5:       c = 16'sd8192;
         default:    c = 16'sd0;
      endcase
      return c;
   endfunction

   function automatic logic signed [15:0] dir_sin(input logic [2:0] idx);
      logic signed [15:0] s;
      case (idx)
         3'd0, 3'd6: s = 16'sd0;
         3'd1, 3'd7: s = 16'sd14189;
         3'd2:       s = 16'sd14189;
         3'd3:       s = 16'sd0;
         3'd4:       s = -16'sd14189;
         3'd5:       s = -16'sd14189;
         default:    s = 16'sd0;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/jtco_req_if.sv
// input channel of the joystick to chamber openings block: one gamepad sample per item
// no dependencies
interface jtco_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_stick_y;
   logic signed [15:0] trigger_up;
   logic signed [15:0] trigger_down;
   logic signed [15:0] right_stick_x;
   logic signed [15:0] right_stick_y;
   logic [5:0]         button_mask;

   modport source (output valid, left_stick_y, trigger_up, trigger_down, right_stick_x,
                   right_stick_y, button_mask, input ready);
   modport sink (input valid, left_stick_y, trigger_up, trigger_down, right_stick_x,
                 right_stick_y, button_mask, output ready);
endinterface

FILE: rtl/jtco_rsp_if.sv
// result channel of the joystick to chamber openings block: one chamber opening per item
// no dependencies
interface jtco_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         chamber;
   logic signed [15:0] opening;
   logic [17:0]        valve_frequency;
   logic               last;

   modport source (output valid, chamber, opening, valve_frequency, last, input ready);
   modport sink (input valid, chamber, opening, valve_frequency, last, output ready);
endinterface

FILE: rtl/jtco_csr.sv
// configuration registers behind the apb-style write/read port
// depends on jtco_pkg
module jtco_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [4:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output jtco_pkg::jtco_cfg_type cfg
);

   jtco_pkg::jtco_cfg_type cfg_ff, cfg_in;
   logic                   wr_en;
   logic [2:0]             idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[4:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            jtco_pkg::REG_DEAD_ZONE: cfg_in.dead_zone        = pwdata[14:0];
            jtco_pkg::REG_SAT_LIMIT: cfg_in.saturation_limit = pwdata[14:0];
            jtco_pkg::REG_PERIOD:    cfg_in.check_period     = pwdata[6:0];
            jtco_pkg::REG_EXTEND:    cfg_in.extend_opening   = pwdata[15:0];
            jtco_pkg::REG_CONTRACT:  cfg_in.contract_opening = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         jtco_pkg::REG_DEAD_ZONE: prdata = {17'd0, cfg_ff.dead_zone};
         jtco_pkg::REG_SAT_LIMIT: prdata = {17'd0, cfg_ff.saturation_limit};
         jtco_pkg::REG_PERIOD:    prdata = {25'd0, cfg_ff.check_period};
         jtco_pkg::REG_EXTEND:    prdata = {{16{cfg_ff.extend_opening[15]}},
                                            cfg_ff.extend_opening};
         jtco_pkg::REG_CONTRACT:  prdata = {{16{cfg_ff.contract_opening[15]}},
                                            cfg_ff.contract_opening};
         default:                 prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone        <= jtco_pkg::DEAD_ZONE_RESET;
         cfg_ff.saturation_limit <= jtco_pkg::SAT_LIMIT_RESET;
         cfg_ff.check_period     <= jtco_pkg::PERIOD_RESET;
         cfg_ff.extend_opening   <= jtco_pkg::EXTEND_RESET;
         cfg_ff.contract_opening <= jtco_pkg::CONTRACT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: rtl/jtco_dp.sv
// datapath: trigger pacing, stick shaping, serial square root, serial divider, output register
// depends on jtco_pkg and jtco_rsp_if
module jtco_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  jtco_pkg::jtco_cfg_type  cfg,
   input  jtco_pkg::jtco_item_type item,
   input  jtco_pkg::jtco_cmd_type  cmd,
   output jtco_pkg::jtco_sts_type  sts,
   jtco_rsp_if.source              rsp
);

   // architectural state
   logic [17:0]        freq_ff, freq_in;
   logic [6:0]         count_ff, count_in;
   logic signed [15:0] base_ff, base_in;
   // item registers
   logic signed [15:0] x_ff, y_ff;
   logic [5:0]         btn_ff;
   // bending term pipeline
   logic [29:0]        sqx_ff, sqy_ff;
   logic [14:0]        m_ff;
   logic               zero_ff;
   logic [47:0]        n_ff, root_ff, bit_ff;
   logic [39:0]        den_ff;
   logic signed [31:0] pc_ff, ps_ff;
   logic               neg_ff;
   logic [30:0]        adot_ff;
   logic [45:0]        mag_ff;
   logic [40:0]        rem_ff;
   logic [16:0]        nlo_ff;
   logic [16:0]        q_ff;
   // output register
   logic               valid_ff;
   logic [2:0]         chamber_ff;
   logic signed [15:0] opening_ff;
   logic [17:0]        freq_out_ff;
   logic               last_ff;

   logic signed [15:0] ly, sx, sy;
   logic [14:0]        ax, ay;
   logic [47:0]        trial_root;
   logic signed [32:0] dot;
   logic [55:0]        numer;
   logic [41:0]        trial;
   logic [40:0]        dvs;
   logic signed [18:0] diff;
   logic signed [15:0] bend_open;

   function automatic logic signed [15:0] shape_axis(input logic signed [15:0] v,
                                                      input logic [14:0] dz,
                                                      input logic [14:0] lim);
      logic signed [16:0] sv, sl;
      logic [16:0]        mag;
      logic signed [15:0] r;
      sv  = {v[15], v};
      sl  = {2'b00, lim};
      mag = (sv < 0) ? 17'(-sv) : 17'(sv);
      if (mag < {2'b00, dz}) r = 16'sd0;
      else if (sv > sl)      r = 16'(sl);
      else if (sv < -sl)     r = 16'(-sl);
      else                   r = v;
      return r;
   endfunction

   function automatic logic [17:0] freq_step(input logic [17:0] u, input logic up,
                                              input logic down);
      logic signed [19:0] d, s;
      logic [17:0]        r;
      d = 20'sd0;
      if (up) begin
         if (u >= 18'd1 && u < 18'd10) d = 20'sd1;
         else if (u < 18'd20)          d = 20'sd2;
         else if (u < 18'd1000)        d = 20'sd20;
         else if (u < 18'd4000)        d = 20'sd40;
         else if (u < 18'd40000)       d = 20'sd200;
         else if (u < 18'd200000)      d = 20'sd2000;
      end else if (down) begin
         if (u > 18'd1 && u <= 18'd10) d = -20'sd1;
         else if (u <= 18'd20)         d = -20'sd2;
         else if (u <= 18'd1000)       d = -20'sd20;
         else if (u <= 18'd4000)       d = -20'sd40;
         else if (u <= 18'd40000)      d = -20'sd200;
         else if (u <= 18'd200000)     d = -20'sd2000;
      end
      s = $signed({2'b00, u}) + d;
      if (d == 20'sd0)                           r = u;
      else if (s < 20'sd1)                       r = 18'd1;
      else if (s > $signed({2'b00, jtco_pkg::FREQ_MAX})) r = jtco_pkg::FREQ_MAX;
      else                                       r = 18'(s);
      return r;
   endfunction

   assign ly = shape_axis($signed(item.left_stick_y), cfg.dead_zone, cfg.saturation_limit);
   assign sx = shape_axis($signed(item.right_stick_x), cfg.dead_zone, cfg.saturation_limit);
   assign sy = shape_axis($signed(item.right_stick_y), cfg.dead_zone, cfg.saturation_limit);

   always_comb begin
      freq_in  = freq_ff;
      count_in = count_ff;
      base_in  = base_ff;
      if (cmd.load) begin
         if (count_ff == 7'd0) begin
            freq_in  = freq_step(freq_ff,
                                 $signed(item.trigger_up) > jtco_pkg::TRIGGER_LEVEL,
                                 $signed(item.trigger_down) > jtco_pkg::TRIGGER_LEVEL);
            count_in = cfg.check_period;
         end else begin
            count_in = count_ff - 7'd1;
         end
         if (item.button_mask == 6'd0) begin
            if (ly > 0)      base_in = $signed(cfg.extend_opening);
            else if (ly < 0) base_in = $signed(cfg.contract_opening);
            else             base_in = 16'sd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff  <= jtco_pkg::FREQ_RESET;
         count_ff <= jtco_pkg::COUNT_RESET;
         base_ff  <= 16'sd0;
      end else begin
         freq_ff  <= freq_in;
         count_ff <= count_in;
         base_ff  <= base_in;
      end
   end

   assign ax         = 15'(x_ff < 0 ? -x_ff : x_ff);
   assign ay         = 15'(y_ff < 0 ? -y_ff : y_ff);
   assign trial_root = root_ff + bit_ff;
   assign dot        = 33'(pc_ff) + 33'(ps_ff);
   assign numer      = {1'b0, mag_ff, 9'd0} + 56'(den_ff);
   assign dvs        = {den_ff, 1'b0};
   assign trial      = {rem_ff, nlo_ff[16]};

   // opening = base minus rounded bending term, saturated
   always_comb begin
      if (zero_ff)     diff = 19'(base_ff);
      else if (neg_ff) diff = 19'(base_ff) + $signed({2'b00, q_ff});
      else             diff = 19'(base_ff) - $signed({2'b00, q_ff});
      if (diff > 19'sd32767)       bend_open = 16'sd32767;
      else if (diff < -19'sd32768) bend_open = -16'sd32768;
      else                         bend_open = 16'(diff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= sx;
         y_ff   <= sy;
         btn_ff <= item.button_mask;
      end
      if (cmd.square) begin
         sqx_ff  <= ax * ax;
         sqy_ff  <= ay * ay;
         m_ff    <= (ax > ay) ? ax : ay;
         zero_ff <= (x_ff == 16'sd0) && (y_ff == 16'sd0);
      end
      if (cmd.root_init) begin
         n_ff    <= {1'b0, 31'(sqx_ff) + 31'(sqy_ff), 16'd0};
         root_ff <= 48'd0;
         bit_ff  <= 48'd1 << 46;
      end
      if (cmd.root_step) begin
         if (n_ff >= trial_root) begin
            n_ff    <= n_ff - trial_root;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.den) begin
         den_ff <= {39'(cfg.saturation_limit) * 39'(root_ff[23:0]), 1'b0};
      end
      if (cmd.dot) begin
         pc_ff <= y_ff * jtco_pkg::dir_cos(cmd.chamber);
         ps_ff <= x_ff * jtco_pkg::dir_sin(cmd.chamber);
      end
      if (cmd.sum) begin
         neg_ff  <= dot < 0;
         adot_ff <= 31'(dot < 0 ? -dot : dot);
      end
      if (cmd.prod) begin
         mag_ff <= adot_ff * m_ff;
      end
      if (cmd.numer) begin
         rem_ff <= 41'(numer[55:17]);
         nlo_ff <= numer[16:0];
         q_ff   <= '0;
      end
      if (cmd.div_step) begin
         if (trial >= {1'b0, dvs}) begin
            rem_ff <= 41'(trial - {1'b0, dvs});
            q_ff   <= {q_ff[15:0], 1'b1};
         end else begin
            rem_ff <= trial[40:0];
            q_ff   <= {q_ff[15:0], 1'b0};
         end
         nlo_ff <= {nlo_ff[15:0], 1'b0};
      end
      if (cmd.emit_bend || cmd.emit_base) begin
         chamber_ff  <= cmd.chamber;
         last_ff     <= cmd.last;
         opening_ff  <= cmd.emit_bend ? bend_open : base_ff;
         freq_out_ff <= freq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.emit_bend || cmd.emit_base) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp.valid           = valid_ff;
   assign rsp.chamber         = chamber_ff;
   assign rsp.opening         = opening_ff;
   assign rsp.valve_frequency = freq_out_ff;
   assign rsp.last            = last_ff;

   assign sts.buttons      = btn_ff;
   assign sts.buttons_zero = (btn_ff == 6'd0);
   assign sts.out_free     = !valid_ff || rsp.ready;

endmodule

FILE: rtl/jtco_ctrl.sv
// sequencer: steps the datapath through root, per-chamber divide and emit, or button scan
// depends on jtco_pkg
module jtco_ctrl #(
   parameter int CHAMBERS = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  jtco_pkg::jtco_sts_type sts,
   output jtco_pkg::jtco_cmd_type cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SQUARE    = 4'd1;
   localparam logic [3:0] S_ROOT_INIT = 4'd2;
   localparam logic [3:0] S_ROOT      = 4'd3;
   localparam logic [3:0] S_DEN       = 4'd4;
   localparam logic [3:0] S_DOT       = 4'd5;
   localparam logic [3:0] S_SUM       = 4'd6;
   localparam logic [3:0] S_PROD      = 4'd7;
   localparam logic [3:0] S_NUMER     = 4'd8;
   localparam logic [3:0] S_DIV       = 4'd9;
   localparam logic [3:0] S_EMIT      = 4'd10;
   localparam logic [3:0] S_SCAN      = 4'd11;

   localparam logic [2:0] LAST_CHAMBER = 3'(CHAMBERS - 1);
   localparam logic [4:0] ROOT_LAST    = 5'(jtco_pkg::ROOT_STEPS - 1);
   localparam logic [4:0] DIV_LAST     = 5'(jtco_pkg::QUOT_BITS - 1);
   // buttons at or above the chamber count are ignored
   localparam logic [5:0] BTN_MASK = (CHAMBERS >= jtco_pkg::BUTTONS) ? 6'h3f :
                                     6'((1 << CHAMBERS) - 1);

   logic [3:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic [2:0] idx_ff, idx_in;
   logic [5:0] pending;
   logic       sel, later;

   assign pending   = (sts.buttons & BTN_MASK) >> idx_ff;
   assign sel       = pending[0];
   assign later     = |pending[5:1];
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      idx_in      = idx_ff;
      cmd         = '0;
      cmd.chamber = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            idx_in     = 3'd0;
            state_in   = sts.buttons_zero ? S_ROOT_INIT : S_SCAN;
         end
         S_ROOT_INIT: begin
            cmd.root_init = 1'b1;
            step_in       = 5'd0;
            state_in      = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + 5'd1;
            if (step_ff == ROOT_LAST) state_in = S_DEN;
         end
         S_DEN: begin
            cmd.den  = 1'b1;
            state_in = S_DOT;
         end
         S_DOT: begin
            cmd.dot  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_PROD;
         end
         S_PROD: begin
            cmd.prod = 1'b1;
            state_in = S_NUMER;
         end
         S_NUMER: begin
            cmd.numer = 1'b1;
            step_in   = 5'd0;
            state_in  = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 5'd1;
            if (step_ff == DIV_LAST) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_bend = 1'b1;
               cmd.last      = (idx_ff == LAST_CHAMBER);
               if (idx_ff == LAST_CHAMBER) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = S_DOT;
               end
            end
         end
         S_SCAN: begin
            if (!sel || sts.out_free) begin
               cmd.emit_base = sel;
               cmd.last      = !later;
               idx_in        = idx_ff + 3'd1;
               if (!later) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= 5'd0;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

FILE: rtl/joystick_to_chamber_openings.sv
// top level: gamepad sample in, one valve opening per chamber (or per selected chamber) out, apb-style registers
// depends on jtco_pkg, jtco_req_if, jtco_rsp_if, jtco_csr, jtco_ctrl, jtco_dp, assert_macros.svh

// One sample is taken at a time. With buttons held it yields one item per selected chamber.
// With no button held every chamber gets an item: a 24-step bit-serial square root runs
// once per sample and a 17-step restoring divider runs once per chamber. A new sample is
// taken while the last item still waits in the output register. The valve frequency on
// every item is the value after this sample's trigger check; configuration writes are
// taken at any time.
`include "assert_macros.svh"

module joystick_to_chamber_openings #(
   parameter int CHAMBERS = 6
) (
   input  logic        clock,
   input  logic        reset,
   jtco_req_if.sink    req,
   jtco_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   jtco_pkg::jtco_cfg_type  cfg;
   jtco_pkg::jtco_item_type item;
   jtco_pkg::jtco_cmd_type  cmd;
   jtco_pkg::jtco_sts_type  sts;
   logic                    freq_ok;
   logic                    chamber_ok;

   assign item.left_stick_y  = req.left_stick_y;
   assign item.trigger_up    = req.trigger_up;
   assign item.trigger_down  = req.trigger_down;
   assign item.right_stick_x = req.right_stick_x;
   assign item.right_stick_y = req.right_stick_y;
   assign item.button_mask   = req.button_mask;

   jtco_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   jtco_ctrl #(.CHAMBERS(CHAMBERS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   jtco_dp u_dp (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .item  (item),
      .cmd   (cmd),
      .sts   (sts),
      .rsp   (rsp)
   );

   assign freq_ok    = (rsp.valve_frequency >= 18'd1) &&
                       (rsp.valve_frequency <= jtco_pkg::FREQ_MAX);
   assign chamber_ok = (rsp.chamber < CHAMBERS);

   `ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready, "sample taken while busy")
   `ASSERT_ALWAYS(a_freq_range, !rsp.valid || freq_ok, "valve frequency out of range")
   `ASSERT_ALWAYS(a_chamber_range, !rsp.valid || chamber_ok, "chamber index beyond count")

endmodule

FILE: test/joystick_to_chamber_openings_tb.sv
// self-checking testbench for joystick_to_chamber_openings: random and directed gamepad samples
// depends on jtco_pkg, jtco_req_if, jtco_rsp_if and the rtl of the block
`timescale 1ns / 1ps

module joystick_to_chamber_openings_tb;

   localparam int NUM_CHAMBERS = 6;
   localparam int CYCLE_LIMIT  = 3000000;

   typedef struct {
      logic [2:0]         chamber;
      logic signed [15:0] opening;
      logic [17:0]        valve_frequency;
      logic               last;
   } opening_cmd_type;

   logic        clock;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   jtco_req_if req_ch ();
   jtco_rsp_if rsp_ch ();

   joystick_to_chamber_openings dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state and register copies
   int dead_zone_cfg, sat_limit_cfg, period_cfg, extend_cfg, contract_cfg;
   int freq_units, countdown, base_opening;
   int dir_cos_tab[NUM_CHAMBERS] = '{16384, 8192, -8192, -16384, -8192, 8192};
   int dir_sin_tab[NUM_CHAMBERS] = '{0, 14189, 14189, 0, -14189, -14189};

   opening_cmd_type expected_openings[$];
   bit  failed;
   int  send_idle_pct, recv_stall_pct;
   int  hold_left;
   longint cycle_count;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // long receiver hold-off, counted down here
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   function automatic int shape_axis(int v);
      if (v < dead_zone_cfg && v > -dead_zone_cfg) return 0;
      if (v > sat_limit_cfg) return sat_limit_cfg;
      if (v < -sat_limit_cfg) return -sat_limit_cfg;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint bending_term(int x, int y, int idx);
      longint ax, ay, m, dot, mag, rq, den;
      bit neg;
      if (x == 0 && y == 0) return 0;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      m = ax > ay ? ax : ay;
      dot = longint'(y) * dir_cos_tab[idx] + longint'(x) * dir_sin_tab[idx];
      neg = dot < 0;
      mag = (neg ? -dot : dot) * m * 256;
      rq = longint'(int_sqrt(longint'(ax * ax + ay * ay) << 16));
      den = 2 * longint'(sat_limit_cfg) * rq;
      if (den == 0) return 0;
      mag = (2 * mag + den) / (2 * den);
      return neg ? -mag : mag;
   endfunction

   function automatic void step_frequency(int up, int down);
      int step;
      step = 0;
      if (up > 100) begin
         if (freq_units >= 1 && freq_units < 10) step = 1;
         else if (freq_units < 20) step = 2;
         else if (freq_units < 1000) step = 20;
         else if (freq_units < 4000) step = 40;
         else if (freq_units < 40000) step = 200;
         else if (freq_units < 200000) step = 2000;
      end else if (down > 100) begin
         if (freq_units > 1 && freq_units <= 10) step = -1;
         else if (freq_units <= 20) step = -2;
         else if (freq_units <= 1000) step = -20;
         else if (freq_units <= 4000) step = -40;
         else if (freq_units <= 40000) step = -200;
         else if (freq_units <= 200000) step = -2000;
      end
      freq_units += step;
      if (freq_units < 1) freq_units = 1;
      if (freq_units > 200000) freq_units = 200000;
   endfunction

   function automatic void predict_openings(jtco_pkg::jtco_item_type s);
      int ly, rx, ry, op, top;
      opening_cmd_type c;
      ly = shape_axis(int'(signed'(s.left_stick_y)));
      if (countdown == 0) begin
         step_frequency(int'(signed'(s.trigger_up)), int'(signed'(s.trigger_down)));
         countdown = period_cfg;
      end else begin
         countdown--;
      end
      if (s.button_mask == 0) begin
         rx = shape_axis(int'(signed'(s.right_stick_x)));
         ry = shape_axis(int'(signed'(s.right_stick_y)));
         base_opening = ly > 0 ? extend_cfg : (ly < 0 ? contract_cfg : 0);
         for (int i = 0; i < NUM_CHAMBERS; i++) begin
            op = base_opening - int'(bending_term(rx, ry, i));
            if (op > 32767) op = 32767;
            if (op < -32768) op = -32768;
            c.chamber = i;
            c.opening = op;
            c.valve_frequency = freq_units;
            c.last = (i == NUM_CHAMBERS - 1);
            expected_openings.push_back(c);
         end
      end else begin
         top = 0;
         for (int i = 0; i < NUM_CHAMBERS; i++) if (s.button_mask[i]) top = i;
         for (int i = 0; i < NUM_CHAMBERS; i++) begin
            if (s.button_mask[i]) begin
               c.chamber = i;
               c.opening = base_opening;
               c.valve_frequency = freq_units;
               c.last = (i == top);
               expected_openings.push_back(c);
            end
         end
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      opening_cmd_type e;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_openings.size() == 0) begin
               $error("opening item with nothing expected, chamber %0d", rsp_ch.chamber);
               failed = 1;
            end else begin
               e = expected_openings.pop_front();
               if (rsp_ch.chamber !== e.chamber) begin
                  $error("chamber: expected %0d, got %0d", e.chamber, rsp_ch.chamber);
                  failed = 1;
               end
               if (rsp_ch.opening !== e.opening) begin
                  $error("opening: expected %0d, got %0d", e.opening, rsp_ch.opening);
                  failed = 1;
               end
               if (rsp_ch.valve_frequency !== e.valve_frequency) begin
                  $error("valve_frequency: expected %0d, got %0d", e.valve_frequency,
                         rsp_ch.valve_frequency);
                  failed = 1;
               end
               if (rsp_ch.last !== e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp_ch.last);
                  failed = 1;
               end
            end
         end
      end
   end

   task automatic send_sample(jtco_pkg::jtco_item_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.left_stick_y  <= s.left_stick_y;
      req_ch.trigger_up    <= s.trigger_up;
      req_ch.trigger_down  <= s.trigger_down;
      req_ch.right_stick_x <= s.right_stick_x;
      req_ch.right_stick_y <= s.right_stick_y;
      req_ch.button_mask   <= s.button_mask;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_openings(s);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_openings.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         jtco_pkg::REG_DEAD_ZONE: dead_zone_cfg = value[14:0];
         jtco_pkg::REG_SAT_LIMIT: sat_limit_cfg = value[14:0];
         jtco_pkg::REG_PERIOD:    period_cfg = value[6:0];
         jtco_pkg::REG_EXTEND:    extend_cfg = int'(signed'(value[15:0]));
         jtco_pkg::REG_CONTRACT:  contract_cfg = int'(signed'(value[15:0]));
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(7))
         0: return 16'sd32767;
         1: return -16'sd32768;
         2: return 16'd0;
         3: return 16'(dead_zone_cfg + int'($urandom_range(4)) - 2);
         4: return 16'(-dead_zone_cfg + int'($urandom_range(4)) - 2);
         5: return 16'(sat_limit_cfg + int'($urandom_range(4)) - 2);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] rand_trigger();
      case ($urandom_range(3))
         0: return 16'sd100;
         1: return 16'sd101;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic jtco_pkg::jtco_item_type rand_sample();
      jtco_pkg::jtco_item_type s;
      s.left_stick_y  = rand_axis();
      s.trigger_up    = rand_trigger();
      s.trigger_down  = rand_trigger();
      s.right_stick_x = rand_axis();
      s.right_stick_y = rand_axis();
      s.button_mask   = $urandom_range(2) == 0 ? 6'd0 : 6'($urandom_range(63));
      return s;
   endfunction

   // stick extremes, dead zone edges and button masks at reset settings
   task automatic test_directed();
      jtco_pkg::jtco_item_type s;
      logic [15:0] axes[8] = '{16'sd32767, -16'sd32768, 16'd0, 16'sd7999, 16'sd8000,
                               -16'sd8000, 16'sd30001, -16'sd30001};
      for (int i = 0; i < 8; i++) begin
         s = '0;
         s.left_stick_y  = axes[i];
         s.right_stick_x = axes[(i + 3) % 8];
         s.right_stick_y = axes[i];
         s.trigger_up    = 16'sd100;
         s.trigger_down  = -16'sd32768;
         send_sample(s);
      end
      s = '0;
      s.left_stick_y = 16'sd32767;
      send_sample(s);
      foreach (axes[i]) if (i < 6) begin
         s = '0;
         s.left_stick_y = axes[i];
         s.button_mask  = i == 0 ? 6'h3F : (i == 1 ? 6'h01 : (i == 2 ? 6'h20 : 6'($urandom)));
         if (s.button_mask == 0) s.button_mask = 6'h2A;
         send_sample(s);
      end
      wait_drained();
   endtask

   // steps the frequency up across the 1000 rung and back down across it
   task automatic test_frequency_ladder();
      jtco_pkg::jtco_item_type s;
      write_reg(jtco_pkg::REG_PERIOD, 32'd0);
      for (int dir = 0; dir < 2; dir++) begin
         do begin
            s = rand_sample();
            if ($urandom_range(9) != 0 && s.button_mask == 0)
               s.button_mask = 6'($urandom_range(1, 63));
            if (dir == 0) begin
               s.trigger_up = 16'($urandom_range(101, 32767));
            end else begin
               s.trigger_up = $urandom_range(1) ? 16'sd100 : 16'($urandom_range(32768, 65535));
               s.trigger_down = 16'($urandom_range(101, 32767));
            end
            send_sample(s);
         end while (dir == 0 ? freq_units < 1080 : freq_units > 960);
      end
      wait_drained();
   endtask

   // walks through register settings, extremes included
   task automatic test_register_settings();
      int dz[4]  = '{0, 32767, 100, 8000};
      int lim[4] = '{1, 32767, 20000, 30000};
      int per[4] = '{127, 3, 0, 20};
      int ext[4] = '{32767, -32768, 0, 8192};
      int con[4] = '{-32768, 32767, -13107, -13107};
      for (int k = 0; k < 4; k++) begin
         write_reg(jtco_pkg::REG_DEAD_ZONE, dz[k]);
         write_reg(jtco_pkg::REG_SAT_LIMIT, lim[k]);
         write_reg(jtco_pkg::REG_PERIOD, per[k]);
         write_reg(jtco_pkg::REG_EXTEND, 32'(ext[k]));
         write_reg(jtco_pkg::REG_CONTRACT, 32'(con[k]));
         repeat (5) send_sample(rand_sample());
         wait_drained();
      end
   endtask

   task automatic test_random_idling();
      int send_pct[4] = '{0, 82, 0, 29};
      int recv_pct[4] = '{0, 0, 82, 29};
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = send_pct[ph];
         recv_stall_pct = recv_pct[ph];
         repeat (15) send_sample(rand_sample());
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_drained();
   endtask

   // receiver holds off while samples keep coming, then the sender waits for all items
   task automatic test_back_pressure();
      hold_left = 500;
      repeat (12) send_sample(rand_sample());
      wait_drained();
      repeat (6) send_sample(rand_sample());
      wait_drained();
   endtask

   initial begin
      failed = 0;
      cycle_count = 0;
      hold_left = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      dead_zone_cfg = 8000;
      sat_limit_cfg = 30000;
      period_cfg = 20;
      extend_cfg = 8192;
      contract_cfg = -13107;
      freq_units = 800;
      countdown = 100;
      base_opening = 0;
      reset <= 1'b1;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      req_ch.valid <= 1'b0;
      req_ch.left_stick_y <= '0;
      req_ch.trigger_up <= '0;
      req_ch.trigger_down <= '0;
      req_ch.right_stick_x <= '0;
      req_ch.right_stick_y <= '0;
      req_ch.button_mask <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_settings();
      test_random_idling();
      test_back_pressure();
      // the first trigger check comes only after the reset countdown has run out
      test_frequency_ladder();
      repeat (200) @(posedge clock);
      if (!failed && expected_openings.size() == 0) begin
         $display("No mismatches found");
      end else begin
         if (expected_openings.size() != 0)
            $error("%0d opening items never arrived", expected_openings.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
